[rtl/core/pn_pkg.sv]
// shared types and constants for the peak normaliser
`default_nettype none
package pn_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TARGET_W = 15;
	localparam int PROD_W   = 32;
	localparam int STEPS    = PROD_W / 2;
	localparam int CNT_W    = $clog2(STEPS);

	localparam logic [TARGET_W-1:0] TARGET_RESET = 15'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN   = 16'h8000;
	localparam logic [SAMPLE_W-1:0] PEAK_MAX     = 16'h8000;

	typedef enum logic [1:0] {
		OP_MEASURE = 2'd0,
		OP_SCALE   = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage
`default_nettype wire

[rtl/core/pn_req_if.sv]
// request channel carrying op and sample
`default_nettype none
interface pn_req_if;
	import pn_pkg::*;

	logic    valid;
	logic    ready;
	op_t     op;
	sample_t sample;

	modport source (output valid, output op, output sample, input ready);
	modport sink   (input valid, input op, input sample, output ready);

endinterface
`default_nettype wire

[rtl/core/pn_rsp_if.sv]
// result channel carrying the scaled sample
`default_nettype none
interface pn_rsp_if;
	import pn_pkg::*;

	logic    valid;
	logic    ready;
	sample_t scaled;

	modport source (output valid, output scaled, input ready);
	modport sink   (input valid, input scaled, output ready);

endinterface
`default_nettype wire

[rtl/core/peak_normalizer.sv]
// peak normaliser: running peak of sample magnitudes and scaling by target over peak
//
// Measure and clear requests complete in the cycle they are accepted and free the
// request side again at once. A scale request passes ST_MUL for the magnitude by
// target multiply, ST_DIV for the divider that retires two quotient bits per cycle,
// and ST_DONE, which saturates into the output register once it is free. The
// divider serves one request at a time, so ready stays low while it runs. A finished
// result waits in the output register while the next request is taken.
`default_nettype none
module peak_normalizer (
	input  wire                             clk,
	input  wire                             arst_n,
	pn_req_if.sink                          samples,
	pn_rsp_if.source                        results,
	input  wire                             cfg_we,
	input  wire [pn_pkg::TARGET_W-1:0]      cfg_wdata
);
	import pn_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t               state_q;
	logic [TARGET_W-1:0]  target_q;
	logic [SAMPLE_W-1:0]  peak_q;
	logic [SAMPLE_W-1:0]  mag_q;
	logic                 neg_q;
	logic [PROD_W-1:0]    dq_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 rsp_valid_q;
	logic [SAMPLE_W-1:0]  scaled_q;

	logic                 req_acc;
	logic [SAMPLE_W-1:0]  req_mag;
	logic [SAMPLE_W:0]    t1, t2, pk_ext;
	logic                 ge1, ge2;
	logic [SAMPLE_W-1:0]  r1, r2;
	logic                 load;
	logic [SAMPLE_W-1:0]  sat;

	assign samples.ready  = (state_q == ST_IDLE);
	assign req_acc        = samples.valid && samples.ready;
	assign req_mag        = samples.sample[SAMPLE_W-1] ? (-samples.sample) : samples.sample;
	assign results.valid  = rsp_valid_q;
	assign results.scaled = scaled_q;
	assign load           = (state_q == ST_DONE) && (!rsp_valid_q || results.ready);

	// two restoring steps per cycle
	always_comb begin
		pk_ext = {1'b0, peak_q};
		t1     = {rem_q, dq_q[PROD_W-1]};
		ge1    = (t1 >= pk_ext);
		r1     = ge1 ? SAMPLE_W'(t1 - pk_ext) : t1[SAMPLE_W-1:0];
		t2     = {r1, dq_q[PROD_W-2]};
		ge2    = (t2 >= pk_ext);
		r2     = ge2 ? SAMPLE_W'(t2 - pk_ext) : t2[SAMPLE_W-1:0];
	end

	// saturation of the quotient
	always_comb begin
		if (peak_q == '0) begin
			sat = '0;
		end else if (neg_q) begin
			if (dq_q > PROD_W'(PEAK_MAX)) sat = SAMPLE_MIN;
			else sat = SAMPLE_W'(-dq_q);
		end else begin
			if (dq_q > PROD_W'(SAMPLE_MAX)) sat = SAMPLE_MAX;
			else sat = dq_q[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			target_q    <= TARGET_RESET;
			peak_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) target_q <= cfg_wdata;
			if (load) rsp_valid_q <= 1'b1;
			else if (results.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						case (samples.op)
							OP_MEASURE: begin
								if (req_mag > peak_q) peak_q <= req_mag;
							end
							OP_CLEAR: peak_q <= '0;
							OP_SCALE: state_q <= ST_MUL;
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mag_q <= req_mag;
				neg_q <= samples.sample[SAMPLE_W-1];
			end
			ST_MUL: begin
				dq_q  <= PROD_W'(mag_q) * PROD_W'(target_q);
				rem_q <= '0;
			end
			ST_DIV: begin
				dq_q  <= {dq_q[PROD_W-3:0], ge1, ge2};
				rem_q <= r2;
			end
			ST_DONE: begin
				if (load) scaled_q <= sat;
			end
			default: ;
		endcase
	end

	a_scale_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && samples.op == OP_SCALE) |=> !samples.ready)
		else $error("scale request did not occupy the divider");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && samples.op == OP_CLEAR) |=> (peak_q == '0))
		else $error("clear request left a peak");

	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q <= PEAK_MAX)
		else $error("peak above full scale");

	a_measure: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && samples.op == OP_MEASURE) |=> (peak_q >= $past(req_mag)))
		else $error("peak below measured magnitude");

	a_zero_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(load && peak_q == '0) |=> (results.valid && results.scaled == '0))
		else $error("zero peak gave a non-zero result");

endmodule
`default_nettype wire
